[hw/rtl/ptw_pkg.sv]
// shared types, constants and helpers for the page table walker
package ptw_pkg;

  // entry layout kept in the table store: frame bits 51:12, flags 2:0
  localparam int ENTRY_W     = 52;
  localparam int FRAME_NUM_W = 40;
  localparam int VPN_W       = 36;
  localparam int VA_W        = 48;
  localparam int IDX_W       = 9;
  localparam int PAGE_SHIFT  = 12;
  localparam int LEVELS      = 4;

  localparam int TABLE_FRAMES_DEF = 64;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_WRITE   = 1;
  localparam int BIT_USER    = 2;

  // request codes
  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_UNMAP = 1'b1;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STATUS_DONE     = 2'd0;
  localparam status_t STATUS_NO_FRAME = 2'd1;
  localparam status_t STATUS_NO_TABLE = 2'd2;

  typedef logic [ENTRY_W-1:0] entry_t;

  // 9-bit table index for a walk level, root level first
  function automatic logic [IDX_W-1:0] level_index(logic [VPN_W-1:0] vpn, logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = vpn[35:27];
      2'd1:    idx = vpn[26:18];
      2'd2:    idx = vpn[17:9];
      default: idx = vpn[8:0];
    endcase
    return idx;
  endfunction

endpackage

[hw/rtl/ptw_store.sv]
// table store memory: one port, registered read data
module ptw_store #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF
) (
  input  logic                                                clk,
  input  logic                                                we,
  input  logic [$clog2(TABLE_FRAMES)+ptw_pkg::IDX_W-1:0]      addr,
  input  ptw_pkg::entry_t                                     wdata,
  output ptw_pkg::entry_t                                     rdata
);
  import ptw_pkg::*;

  localparam int DEPTH = TABLE_FRAMES * (1 << IDX_W);

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

[hw/rtl/ptw_addsub.sv]
// shared 40-bit frame adder: relocates links in and out of the store
module ptw_addsub (
  input  logic [ptw_pkg::FRAME_NUM_W-1:0] a,
  input  logic [ptw_pkg::FRAME_NUM_W-1:0] b,
  input  logic                            sub,
  output logic [ptw_pkg::FRAME_NUM_W-1:0] sum
);
  import ptw_pkg::*;

  // wraps modulo 2^40 either way
  always_comb begin
    if (sub) begin
      sum = a - b;
    end else begin
      sum = a + b;
    end
  end

endmodule

[hw/rtl/page_table_map_unmap_walker.sv]
// page table walker top level: request sequencer around the table store
//
// Keeps a four-level x86-64 page table in an internal store of TABLE_FRAMES
// frames of 512 entries; frame 0 is the root. Requests arrive on the in_*
// channel (map or unmap of one 4 KiB page) and each one produces exactly one
// result on the out_* channel: a status and the page number to invalidate.
// A transfer happens at a clock edge with valid high and stall low.
// One request is worked on at a time; in_stall is high while it walks.
// Each of the three table levels above the leaf takes a store read and an
// evaluate step; a walk that finds all tables present then writes the leaf
// entry and registers the result, and the next request is taken only once
// the walker is back in idle. Every table allocated on a map is cleared one
// entry at a time and then linked; the single store port serializes this work.
// cfg_we/cfg_data write table_base_frame, the physical frame of store frame 0.
// After rst the root table is cleared entry by entry with in_stall high.
// A finished result waits in the output register while out_stall is high;
// the next request may already be accepted and walks behind it.
module page_table_map_unmap_walker #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [ptw_pkg::FRAME_NUM_W-1:0]  cfg_data,
  // request channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [ptw_pkg::VA_W-1:0]         vaddr,
  input  logic [ptw_pkg::FRAME_NUM_W-1:0]  physical_frame,
  input  logic                             writable,
  input  logic                             user_access,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       status,
  output logic [ptw_pkg::VPN_W-1:0]        flush_page
);
  import ptw_pkg::*;

  localparam int FW  = $clog2(TABLE_FRAMES);
  localparam int NFW = $clog2(TABLE_FRAMES + 1);
  localparam int AW  = FW + IDX_W;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_LINK,
    S_LEAF,
    S_RESULT
  } state_t;

  state_t                  state;
  logic [FRAME_NUM_W-1:0]  table_base_frame;
  logic [NFW-1:0]          next_free_frame;
  logic [FW-1:0]           frame;
  logic [1:0]              lvl;
  logic [FW-1:0]           clr_frame;
  logic [IDX_W-1:0]        clr_cnt;
  logic                    clr_init;
  logic                    req;
  logic [VPN_W-1:0]        vpn;
  logic [FRAME_NUM_W-1:0]  pf;
  logic                    wr;
  logic                    us;
  status_t                 res_status;

  logic                    mem_we;
  logic [AW-1:0]           mem_addr;
  entry_t                  mem_wdata;
  entry_t                  mem_rdata;

  logic [FRAME_NUM_W-1:0]  add_a;
  logic                    add_sub;
  logic [FRAME_NUM_W-1:0]  add_sum;
  logic                    child_ok;
  logic                    pool_empty;

  ptw_store #(.TABLE_FRAMES(TABLE_FRAMES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ptw_addsub u_addsub (
    .a   (add_a),
    .b   (table_base_frame),
    .sub (add_sub),
    .sum (add_sum)
  );

  // adder: unlink a read entry, or relocate a fresh frame for a link
  always_comb begin
    if (state == S_LINK) begin
      add_a   = FRAME_NUM_W'(clr_frame);
      add_sub = 1'b0;
    end else begin
      add_a   = mem_rdata[ENTRY_W-1:PAGE_SHIFT];
      add_sub = 1'b1;
    end
  end

  // entry links to an already allocated table
  assign child_ok   = mem_rdata[BIT_PRESENT] &&
                      (add_sum < FRAME_NUM_W'(next_free_frame));
  assign pool_empty = (next_free_frame == NFW'(TABLE_FRAMES));

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = '0;
    mem_addr  = {frame, level_index(vpn, lvl)};
    case (state)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = {clr_frame, clr_cnt};
      end
      S_EVAL: begin
        mem_we    = child_ok && (req == REQ_MAP);
        mem_wdata = mem_rdata;
        mem_wdata[BIT_WRITE] = 1'b1;
        mem_wdata[BIT_USER]  = 1'b1;
      end
      S_LINK: begin
        mem_we    = 1'b1;
        mem_wdata = {add_sum, (PAGE_SHIFT-3)'(0), 3'b111};
      end
      S_LEAF: begin
        mem_we = 1'b1;
        if (req == REQ_MAP) begin
          mem_wdata = {pf, (PAGE_SHIFT-3)'(0), us, wr, 1'b1};
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_base_frame <= '0;
    end else if (cfg_we) begin
      table_base_frame <= cfg_data;
    end
  end

  // walk sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      next_free_frame <= NFW'(1);
      clr_frame       <= '0;
      clr_cnt         <= '0;
      clr_init        <= 1'b1;
      out_valid       <= 1'b0;
      frame           <= '0;
      lvl             <= '0;
    end else begin
      // result taken and nothing new loaded behind it
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end
      case (state)
        // zero one table frame, one entry a cycle
        S_CLEAR: begin
          clr_cnt <= clr_cnt + IDX_W'(1);
          if (clr_cnt == {IDX_W{1'b1}}) begin
            state <= clr_init ? S_IDLE : S_LINK;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= req_type;
            vpn   <= vaddr[VA_W-1:PAGE_SHIFT];
            pf    <= physical_frame;
            wr    <= writable;
            us    <= user_access;
            frame <= '0;
            lvl   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        // decide on the entry just read
        S_EVAL: begin
          if (child_ok) begin
            frame <= add_sum[FW-1:0];
            lvl   <= lvl + 2'd1;
            state <= (lvl == 2'd2) ? S_LEAF : S_READ;
          end else if (req == REQ_UNMAP) begin
            res_status <= STATUS_NO_TABLE;
            state      <= S_RESULT;
          end else if (pool_empty) begin
            res_status <= STATUS_NO_FRAME;
            state      <= S_RESULT;
          end else begin
            clr_frame       <= next_free_frame[FW-1:0];
            clr_cnt         <= '0;
            clr_init        <= 1'b0;
            next_free_frame <= next_free_frame + NFW'(1);
            state           <= S_CLEAR;
          end
        end
        // link the freshly cleared table into the parent entry
        S_LINK: begin
          frame <= clr_frame;
          lvl   <= lvl + 2'd1;
          state <= (lvl == 2'd2) ? S_LEAF : S_READ;
        end
        S_LEAF: begin
          res_status <= STATUS_DONE;
          state      <= S_RESULT;
        end
        // hand over once the output register is free
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            flush_page <= (res_status == STATUS_DONE) ? vpn : '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/ptw_walk_checker.sv]
`timescale 1ns / 100ps
// result checker for the page table walker: mirrors the tables and compares each result
module ptw_walk_checker #(
  parameter int TABLE_FRAMES = ptw_pkg::TABLE_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ptw_pkg::FRAME_NUM_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            req_type,
  input  logic [ptw_pkg::VA_W-1:0]        vaddr,
  input  logic [ptw_pkg::FRAME_NUM_W-1:0] physical_frame,
  input  logic                            writable,
  input  logic                            user_access,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      status,
  input  logic [ptw_pkg::VPN_W-1:0]       flush_page,
  input  logic                            drain_done,
  output int                              errors
);
  import ptw_pkg::*;

  localparam int SLOTS = 1 << IDX_W;

  typedef struct {
    status_t          status;
    logic [VPN_W-1:0] page;
  } walk_result_t;

  // mirror of the table store and the frame pool
  entry_t                 table_img [TABLE_FRAMES*SLOTS];
  int                     next_free;
  logic [FRAME_NUM_W-1:0] base_frame;
  walk_result_t           expected_flushes [$];
  bit                     leftovers_checked;

  initial errors = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // store frame an entry points to, or -1 when absent or not yet allocated
  function automatic int linked_frame(entry_t e);
    logic [FRAME_NUM_W-1:0] f;
    f = e[ENTRY_W-1:PAGE_SHIFT] - base_frame;
    if (!e[BIT_PRESENT] || f >= FRAME_NUM_W'(next_free)) return -1;
    return int'(f);
  endfunction

  // walk levels 4..2, allocating for map, then update the leaf
  task automatic walk_tables(input logic rq, input logic [VA_W-1:0] va,
                             input logic [FRAME_NUM_W-1:0] pf, input logic wr,
                             input logic us, output walk_result_t res);
    logic [VPN_W-1:0] vpn;
    logic [IDX_W-1:0] idx;
    int               frame;
    int               child;
    int               s;
    vpn = va[VA_W-1:PAGE_SHIFT];
    frame = 0;
    res.status = STATUS_DONE;
    res.page = '0;
    for (int lvl = 0; lvl < LEVELS - 1; lvl++) begin
      idx = IDX_W'(vpn >> (IDX_W * (LEVELS - 1 - lvl)));
      s = frame * SLOTS + int'(idx);
      child = linked_frame(table_img[s]);
      if (child < 0) begin
        // unmap gives up at the first missing table
        if (rq == REQ_UNMAP) begin
          res.status = STATUS_NO_TABLE;
          return;
        end
        // pool empty: tables taken earlier in this walk stay linked
        if (next_free >= TABLE_FRAMES) begin
          res.status = STATUS_NO_FRAME;
          return;
        end
        child = next_free;
        next_free++;
        for (int k = 0; k < SLOTS; k++) table_img[child*SLOTS + k] = '0;
        table_img[s] = {FRAME_NUM_W'(child) + base_frame, PAGE_SHIFT'(0)};
        table_img[s][BIT_PRESENT] = 1'b1;
      end
      // map widens every intermediate entry it passes
      if (rq == REQ_MAP) begin
        table_img[s][BIT_WRITE] = 1'b1;
        table_img[s][BIT_USER]  = 1'b1;
      end
      frame = child;
    end
    s = frame * SLOTS + int'(vpn[IDX_W-1:0]);
    if (rq == REQ_MAP) begin
      table_img[s] = {pf, PAGE_SHIFT'(0)};
      table_img[s][BIT_PRESENT] = 1'b1;
      table_img[s][BIT_WRITE]   = wr;
      table_img[s][BIT_USER]    = us;
    end else begin
      table_img[s] = '0;
    end
    res.page = vpn;
  endtask

  always @(posedge clk) begin : monitor
    walk_result_t want;
    if (rst) begin
      for (int k = 0; k < TABLE_FRAMES*SLOTS; k++) table_img[k] = '0;
      next_free = 1;
      base_frame = '0;
      expected_flushes.delete();
      leftovers_checked = 1'b0;
    end else begin
      // result transfer: always belongs to an older request
      if (out_valid && !out_stall) begin
        if (expected_flushes.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d page %h",
                                    status, flush_page));
        end else begin
          want = expected_flushes.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %0d (page %h)",
                                      status, want.status, want.page));
          if (flush_page !== want.page)
            report_mismatch($sformatf("flush_page %h, wanted %h", flush_page, want.page));
        end
      end
      if (cfg_we) base_frame = cfg_data;
      // request transfer
      if (in_valid && !in_stall) begin
        walk_tables(req_type, vaddr, physical_frame, writable, user_access, want);
        expected_flushes.push_back(want);
      end
      if (drain_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_flushes.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_flushes.size()));
      end
    end
  end

endmodule

[dv/tb_page_table_map_unmap_walker.sv]
`timescale 1ns / 100ps
// testbench top for the page table walker: clock, reset, stimulus and verdict
module tb_page_table_map_unmap_walker;
  import ptw_pkg::*;

  localparam int TABLE_FRAMES = TABLE_FRAMES_DEF;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [FRAME_NUM_W-1:0] cfg_data;
  logic                   in_valid;
  logic                   in_stall;
  logic                   req_type;
  logic [VA_W-1:0]        vaddr;
  logic [FRAME_NUM_W-1:0] physical_frame;
  logic                   writable;
  logic                   user_access;
  logic                   out_valid;
  logic                   out_stall;
  logic [1:0]             status;
  logic [VPN_W-1:0]       flush_page;
  logic                   drain_done;
  int                     errors;

  // stimulus bookkeeping
  int                     requests_sent = 0;
  int                     results_taken = 0;
  bit                     calm = 1'b0;
  logic [IDX_W-1:0]       hot_idx [3][2];
  logic [IDX_W-1:0]       hot_leaf [8];

  page_table_map_unmap_walker #(.TABLE_FRAMES(TABLE_FRAMES)) DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .vaddr           (vaddr),
    .physical_frame  (physical_frame),
    .writable        (writable),
    .user_access     (user_access),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .flush_page      (flush_page)
  );

  ptw_walk_checker #(.TABLE_FRAMES(TABLE_FRAMES)) walk_check (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .req_type        (req_type),
    .vaddr           (vaddr),
    .physical_frame  (physical_frame),
    .writable        (writable),
    .user_access     (user_access),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .flush_page      (flush_page),
    .drain_done      (drain_done),
    .errors          (errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, one long hold-off, a calm stretch
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) results_taken++;
      if (!hold_done && results_taken == 300) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 16);
      end
    end
  end

  // one request transfer, with random idle cycles ahead of it
  task automatic send_request(input logic rq, input logic [VA_W-1:0] va,
                              input logic [FRAME_NUM_W-1:0] pf, input logic wr,
                              input logic us);
    calm = (requests_sent >= 500) && (requests_sent < 620);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= rq;
    vaddr           <= va;
    physical_frame  <= pf;
    writable        <= wr;
    user_access     <= us;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // stop offering and let every pending result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_taken < requests_sent) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_base(input logic [FRAME_NUM_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // a small set of table paths that most requests walk
  function automatic void choose_hot_set(input bit edges);
    for (int l = 0; l < 3; l++) begin
      hot_idx[l][0] = edges ? '0 : IDX_W'($urandom);
      hot_idx[l][1] = edges ? '1 : IDX_W'($urandom);
    end
    foreach (hot_leaf[j]) hot_leaf[j] = IDX_W'($urandom);
  endfunction

  // mostly walks over the hot paths, some random and broken walks
  task automatic run_phase(input int count, input int fresh_pct);
    logic                   rq;
    logic [VA_W-1:0]        va;
    logic [IDX_W-1:0]       leaf;
    int                     pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      rq = ($urandom_range(99) < 40) ? REQ_UNMAP : REQ_MAP;
      va = VA_W'({$urandom(), $urandom()});
      if (pick >= fresh_pct && pick < fresh_pct + 8) begin
        // known root, random lower levels: unmap runs into missing tables
        rq = REQ_UNMAP;
        va[47:39] = hot_idx[0][$urandom_range(1)];
      end else if (pick >= fresh_pct + 8) begin
        leaf = $urandom_range(1) ? hot_leaf[$urandom_range(7)] : IDX_W'($urandom);
        va[47:12] = {hot_idx[0][$urandom_range(1)], hot_idx[1][$urandom_range(1)],
                     hot_idx[2][$urandom_range(1)], leaf};
      end
      send_request(rq, va, FRAME_NUM_W'({$urandom(), $urandom()}),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    in_valid        = 1'b0;
    req_type        = REQ_MAP;
    vaddr           = '0;
    physical_frame  = '0;
    writable        = 1'b0;
    user_access     = 1'b0;
    drain_done      = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_base('0);
    choose_hot_set(1'b1);

    // empty table, first allocations, leaf overwrite, unmap twice
    send_request(REQ_UNMAP, 48'h0000_0000_0000, 40'h00_0000_0000, 1'b0, 1'b0);
    send_request(REQ_MAP,   48'h0000_0000_0000, 40'h00_0000_0000, 1'b0, 1'b0);
    send_request(REQ_MAP,   48'h0000_0000_0FFF, 40'hFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(REQ_UNMAP, 48'h0000_0000_0000, 40'h00_0000_0000, 1'b0, 1'b0);
    send_request(REQ_UNMAP, 48'h0000_0000_0000, 40'h00_0000_0000, 1'b0, 1'b0);
    // top of the address space
    send_request(REQ_MAP,   48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 1'b1, 1'b0);
    send_request(REQ_MAP,   48'hFFFF_FFFF_F000, 40'h00_0000_0000, 1'b0, 1'b1);
    // absent leaf in a present table, then missing tables at each level
    send_request(REQ_UNMAP, 48'h0000_0000_1FFF, 40'h00_0000_0000, 1'b0, 1'b0);
    send_request(REQ_UNMAP, 48'h8000_0000_0000, 40'h00_0000_0000, 1'b0, 1'b0);
    send_request(REQ_MAP,   48'h0000_0020_0000, 40'h12_3456_789A, 1'b1, 1'b1);
    send_request(REQ_UNMAP, 48'h0000_4000_0000, 40'h00_0000_0000, 1'b0, 1'b0);
    send_request(REQ_UNMAP, 48'h0000_0040_0000, 40'h00_0000_0000, 1'b0, 1'b0);
    // alternating bit patterns
    send_request(REQ_MAP,   48'hAAAA_AAAA_AAAA, 40'h55_5555_5555, 1'b0, 1'b1);
    send_request(REQ_MAP,   48'h5555_5555_5555, 40'hAA_AAAA_AAAA, 1'b1, 1'b0);
    send_request(REQ_UNMAP, 48'hAAAA_AAAA_AAAA, 40'h00_0000_0000, 1'b0, 1'b0);
    send_request(REQ_UNMAP, 48'h5555_5555_5555, 40'h00_0000_0000, 1'b0, 1'b0);
    run_phase(230, 4);

    // largest base: old links now point one frame further on
    wait_drained();
    write_base(40'hFF_FFFF_FFFF);
    run_phase(220, 4);

    // random base: old links go stale
    wait_drained();
    write_base(FRAME_NUM_W'({$urandom(), $urandom()}));
    send_request(REQ_MAP,   48'h0000_0000_0000, FRAME_NUM_W'({$urandom(), $urandom()}),
                 1'b1, 1'b1);
    send_request(REQ_UNMAP, 48'hFFFF_FFFF_FFFF, 40'h00_0000_0000, 1'b0, 1'b0);
    choose_hot_set(1'b0);
    run_phase(220, 4);

    // base back to zero: first-phase tables come back, pool runs dry
    wait_drained();
    write_base('0);
    choose_hot_set(1'b1);
    run_phase(220, 12);

    wait_drained();
    repeat (64) @(posedge clk);
    drain_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
